// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL of the tile wall collision block.
// Depends on nothing; the assertions compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	`ASSERT_PROP(lbl, clk, rst_n, !(expr), msg)
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

// ===== hdl/twcc_pkg.sv =====
// Types and fixed constants of the tile wall circle collision block.
// Depends on nothing; used by the top level.
`default_nettype none

package twcc_pkg;

	localparam int POS_W       = 24;
	localparam int TILE_W      = 6;
	localparam int WALL_W      = 8;
	localparam int WALL_USED_W = 4;
	localparam int SIZE_W      = 7;
	localparam int RAD_W       = 8;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 8;

	localparam logic [SIZE_W-1:0] MAP_SIZE_RESET = 7'd64;
	localparam logic [RAD_W-1:0]  RADIUS_RESET   = 8'd64;

	// Bit positions inside a wall byte.
	localparam int BIT_EAST  = 0;
	localparam int BIT_NORTH = 1;
	localparam int BIT_WEST  = 2;
	localparam int BIT_SOUTH = 3;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_CHECK = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAP_WIDTH  = 2'd0,
		REG_MAP_HEIGHT = 2'd1,
		REG_RADIUS     = 2'd2
	} cfg_reg_t;

endpackage

`default_nettype wire

// ===== hdl/twcc_ram.sv =====
// Generic simple dual-read RAM: one write port, two registered read ports.
// Depends on nothing; a read at the address being written returns old data.
`default_nettype none

module twcc_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

`default_nettype wire

// ===== hdl/tile_wall_circle_collision.sv =====
// Top level of the tile wall circle collision block: wall store and check pipeline.
// Depends on twcc_pkg, twcc_ram and assert_macros.svh.
//
//   channel   handshake            payload
//   request   start / busy         req_type tile_col tile_row wall_bits pos_x pos_y
//   result    done (strobe)        fixed_x fixed_y
//   config    cfg_valid/cfg_ready  cfg_index cfg_data
//
// One request is taken per cycle while busy is low. A check returns its result with
// done high once it has passed operand sums, wall store read, decision and
// saturation; a write returns nothing. Throughput is set by the two read ports of
// the wall store, which serve the home tile and the diagonal tile of a check at once.
// After reset all 2^(2*ceil(log2 MAX_SIDE)) store entries (4096 at the default size)
// are swept to zero, one entry a cycle, with busy high. The result side cannot stall.
`default_nettype none
`include "assert_macros.svh"

module tile_wall_circle_collision #(
	parameter int MAX_SIDE  = 64,
	parameter int FRAC_BITS = 8
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic                                   req_type,
	input  logic [twcc_pkg::TILE_W-1:0]            tile_col,
	input  logic [twcc_pkg::TILE_W-1:0]            tile_row,
	input  logic [twcc_pkg::WALL_W-1:0]            wall_bits,
	input  logic signed [twcc_pkg::POS_W-1:0]      pos_x,
	input  logic signed [twcc_pkg::POS_W-1:0]      pos_y,
	output logic                                   done,
	output logic signed [twcc_pkg::POS_W-1:0]      fixed_x,
	output logic signed [twcc_pkg::POS_W-1:0]      fixed_y,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [twcc_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [twcc_pkg::CFG_DATA_W-1:0]        cfg_data
);

	localparam int P      = twcc_pkg::POS_W;
	localparam int EW     = P + 2;
	localparam int TW     = EW - FRAC_BITS;
	localparam int SIDE_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
	localparam int XW     = (TW > SIDE_W + 1) ? TW : SIDE_W + 1;
	localparam int ADDR_W = 2 * SIDE_W;
	localparam int DEPTH  = 1 << ADDR_W;
	localparam int WU     = twcc_pkg::WALL_USED_W;
	localparam int DW     = FRAC_BITS + 1;

	localparam logic [XW-1:0] SIDE_LIM = XW'(MAX_SIDE);
	localparam logic [EW-1:0] ONE_E    = EW'(64'd1 << FRAC_BITS);
	localparam logic [DW-1:0] ONE_D    = DW'(64'd1 << FRAC_BITS);

	typedef enum logic [1:0] {SEL_KEEP, SEL_LO, SEL_HI} sel_t;

	function automatic logic in_map(input logic signed [XW-1:0] c,
			input logic signed [XW-1:0] r, input logic [XW-1:0] wlim,
			input logic [XW-1:0] hlim);
		logic [XW-1:0] cu;
		logic [XW-1:0] ru;
		cu = $unsigned(c);
		ru = $unsigned(r);
		return !c[XW-1] && !r[XW-1] && (cu < wlim) && (ru < hlim)
			&& (cu < SIDE_LIM) && (ru < SIDE_LIM);
	endfunction

	function automatic logic signed [XW-1:0] tile_of(input logic signed [EW-1:0] v);
		return XW'(signed'(v[EW-1:FRAC_BITS]));
	endfunction

	function automatic logic signed [P-1:0] sat(input logic signed [EW-1:0] v);
		logic top_same;
		top_same = (v[EW-1:P-1] == '0) || (v[EW-1:P-1] == '1);
		if (top_same) begin
			return v[P-1:0];
		end else if (v[EW-1]) begin
			return {1'b1, {(P-1){1'b0}}};
		end else begin
			return {1'b0, {(P-1){1'b1}}};
		end
	endfunction

	// Configuration registers and the clearing sweep.
	logic [twcc_pkg::SIZE_W-1:0] map_w_q;
	logic [twcc_pkg::SIZE_W-1:0] map_h_q;
	logic [twcc_pkg::RAD_W-1:0]  radius_q;
	logic                        clr_q;
	logic [ADDR_W-1:0]           clr_addr_q;

	assign cfg_ready = 1'b1;
	assign busy      = clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_w_q    <= twcc_pkg::MAP_SIZE_RESET;
			map_h_q    <= twcc_pkg::MAP_SIZE_RESET;
			radius_q   <= twcc_pkg::RADIUS_RESET;
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (twcc_pkg::cfg_reg_t'(cfg_index))
					twcc_pkg::REG_MAP_WIDTH: begin
						map_w_q <= cfg_data[twcc_pkg::SIZE_W-1:0];
					end
					twcc_pkg::REG_MAP_HEIGHT: begin
						map_h_q <= cfg_data[twcc_pkg::SIZE_W-1:0];
					end
					twcc_pkg::REG_RADIUS: begin
						radius_q <= cfg_data[twcc_pkg::RAD_W-1:0];
					end
					default: begin
					end
				endcase
			end
			if (clr_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == '1) begin
					clr_q <= 1'b0;
				end
			end
		end
	end

	// Request intake. Writes go straight to the store; checks enter the pipeline.
	logic              accept;
	logic              chk_acc;
	logic              wr_acc;
	logic [XW-1:0]     wcol;
	logic [XW-1:0]     wrow;
	logic              wr_ok;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [WU-1:0]     ram_wdata;
	logic [EW-1:0]     r_e;

	assign accept  = start && !busy;
	assign chk_acc = accept && (req_type == twcc_pkg::REQ_CHECK);
	assign wr_acc  = accept && (req_type == twcc_pkg::REQ_WRITE);
	assign wcol    = XW'(tile_col);
	assign wrow    = XW'(tile_row);
	assign wr_ok   = (wcol < SIDE_LIM) && (wrow < SIDE_LIM);
	assign r_e     = EW'(radius_q);

	assign ram_we    = clr_q || (wr_acc && wr_ok);
	assign ram_waddr = clr_q ? clr_addr_q : {wrow[SIDE_W-1:0], wcol[SIDE_W-1:0]};
	assign ram_wdata = clr_q ? '0 : wall_bits[WU-1:0];

	// Stage 1: circle extents.
	logic                 v_s1;
	logic signed [P-1:0]  px_s1;
	logic signed [P-1:0]  py_s1;
	logic signed [EW-1:0] pxm_s1;
	logic signed [EW-1:0] pxp_s1;
	logic signed [EW-1:0] pym_s1;
	logic signed [EW-1:0] pyp_s1;

	always_ff @(posedge clk) begin
		px_s1  <= pos_x;
		py_s1  <= pos_y;
		pxm_s1 <= EW'(pos_x) - signed'(r_e);
		pxp_s1 <= EW'(pos_x) + signed'(r_e);
		pym_s1 <= EW'(pos_y) - signed'(r_e);
		pyp_s1 <= EW'(pos_y) + signed'(r_e);
	end

	// Stage 2: tile indices, edge crossings and wall store reads.
	logic signed [XW-1:0] x_t;
	logic signed [XW-1:0] y_t;
	logic signed [XW-1:0] w_t;
	logic signed [XW-1:0] e_t;
	logic signed [XW-1:0] s_t;
	logic signed [XW-1:0] n_t;
	logic signed [XW-1:0] nx_t;
	logic signed [XW-1:0] ny_t;
	logic [XW-1:0]        wlim;
	logic [XW-1:0]        hlim;
	logic                 cw;
	logic                 ce;
	logic                 cs;
	logic                 cn;
	logic [ADDR_W-1:0]    here_addr;
	logic [ADDR_W-1:0]    diag_addr;
	logic [WU-1:0]        here_rd;
	logic [WU-1:0]        diag_rd;

	assign x_t  = tile_of(EW'(px_s1));
	assign y_t  = tile_of(EW'(py_s1));
	assign w_t  = tile_of(pxm_s1);
	assign e_t  = tile_of(pxp_s1);
	assign s_t  = tile_of(pym_s1);
	assign n_t  = tile_of(pyp_s1);
	assign cw   = w_t < x_t;
	assign ce   = e_t > x_t;
	assign cs   = s_t < y_t;
	assign cn   = n_t > y_t;
	assign nx_t = cw ? w_t : e_t;
	assign ny_t = cs ? s_t : n_t;
	assign wlim = XW'(map_w_q);
	assign hlim = XW'(map_h_q);
	assign here_addr = {y_t[SIDE_W-1:0], x_t[SIDE_W-1:0]};
	assign diag_addr = {ny_t[SIDE_W-1:0], nx_t[SIDE_W-1:0]};

	twcc_ram #(
		.WIDTH (WU),
		.DEPTH (DEPTH)
	) u_store (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.raddr_a (here_addr),
		.rdata_a (here_rd),
		.raddr_b (diag_addr),
		.rdata_b (diag_rd)
	);

	logic                v_s2;
	logic signed [P-1:0] px_s2;
	logic signed [P-1:0] py_s2;
	logic                cw_s2;
	logic                ce_s2;
	logic                cs_s2;
	logic                cn_s2;
	logic                here_ok_s2;
	logic                diag_ok_s2;

	always_ff @(posedge clk) begin
		px_s2      <= px_s1;
		py_s2      <= py_s1;
		cw_s2      <= cw;
		ce_s2      <= ce;
		cs_s2      <= cs;
		cn_s2      <= cn;
		here_ok_s2 <= in_map(x_t, y_t, wlim, hlim);
		diag_ok_s2 <= in_map(nx_t, ny_t, wlim, hlim);
	end

	// Stage 3: wall decision and corrected coordinates.
	logic [WU-1:0]        here;
	logic [WU-1:0]        diag;
	logic signed [EW-1:0] px_e;
	logic signed [EW-1:0] py_e;
	logic signed [EW-1:0] x_lo;
	logic signed [EW-1:0] x_hi;
	logic signed [EW-1:0] y_lo;
	logic signed [EW-1:0] y_hi;
	logic [FRAC_BITS-1:0] fx;
	logic [FRAC_BITS-1:0] fy;
	logic [DW-1:0]        gap_w;
	logic [DW-1:0]        gap_e;
	logic [DW-1:0]        y_dist;
	logic                 here_y;
	logic                 diag_y;
	logic                 y_done;
	sel_t                 y_fix;
	sel_t                 xs;
	sel_t                 ys;
	logic signed [EW-1:0] nx_val;
	logic signed [EW-1:0] ny_val;

	assign here = here_ok_s2 ? here_rd : '0;
	assign diag = diag_ok_s2 ? diag_rd : '0;
	assign px_e = EW'(px_s2);
	assign py_e = EW'(py_s2);
	assign x_lo = {px_e[EW-1:FRAC_BITS], {FRAC_BITS{1'b0}}} + signed'(r_e);
	assign x_hi = {px_e[EW-1:FRAC_BITS], {FRAC_BITS{1'b0}}} + signed'(ONE_E - r_e);
	assign y_lo = {py_e[EW-1:FRAC_BITS], {FRAC_BITS{1'b0}}} + signed'(r_e);
	assign y_hi = {py_e[EW-1:FRAC_BITS], {FRAC_BITS{1'b0}}} + signed'(ONE_E - r_e);
	assign fx   = px_s2[FRAC_BITS-1:0];
	assign fy   = py_s2[FRAC_BITS-1:0];
	assign gap_w = DW'(fx);
	assign gap_e = (fx == '0) ? '0 : ONE_D - DW'(fx);

	// A southward crossing is fixed off a south wall, else off a north wall; the
	// diagonal tile blocks with its wall that faces the home row.
	assign y_dist = cs_s2 ? DW'(fy) : ((fy == '0) ? '0 : ONE_D - DW'(fy));
	assign here_y = cs_s2 ? here[twcc_pkg::BIT_SOUTH] : here[twcc_pkg::BIT_NORTH];
	assign diag_y = cs_s2 ? diag[twcc_pkg::BIT_NORTH] : diag[twcc_pkg::BIT_SOUTH];
	assign y_fix  = cs_s2 ? SEL_LO : SEL_HI;
	assign y_done = here_y;

	always_comb begin
		xs = SEL_KEEP;
		ys = SEL_KEEP;
		if (cs_s2 || cn_s2) begin
			if (y_done) begin
				ys = y_fix;
			end
			if (cw_s2) begin
				if (here[twcc_pkg::BIT_WEST]) begin
					xs = SEL_LO;
				end else if (!y_done && (diag_y || diag[twcc_pkg::BIT_EAST])) begin
					// Corner hit: move along the axis that needs less; ties go to x.
					if (y_dist > gap_w) begin
						ys = y_fix;
					end else begin
						xs = SEL_LO;
					end
				end
			end else if (ce_s2) begin
				if (here[twcc_pkg::BIT_EAST]) begin
					xs = SEL_HI;
				end else if (!y_done && (diag_y || diag[twcc_pkg::BIT_WEST])) begin
					if (y_dist > gap_e) begin
						ys = y_fix;
					end else begin
						xs = SEL_HI;
					end
				end
			end
		end else if (cw_s2) begin
			if (here[twcc_pkg::BIT_WEST]) begin
				xs = SEL_LO;
			end
		end else if (ce_s2) begin
			if (here[twcc_pkg::BIT_EAST]) begin
				xs = SEL_HI;
			end
		end
	end

	always_comb begin
		case (xs)
			SEL_LO:  nx_val = x_lo;
			SEL_HI:  nx_val = x_hi;
			default: nx_val = px_e;
		endcase
		case (ys)
			SEL_LO:  ny_val = y_lo;
			SEL_HI:  ny_val = y_hi;
			default: ny_val = py_e;
		endcase
	end

	logic                 v_s3;
	logic signed [EW-1:0] px_s3;
	logic signed [EW-1:0] py_s3;

	always_ff @(posedge clk) begin
		px_s3 <= nx_val;
		py_s3 <= ny_val;
	end

	// Stage 4: saturation into the result registers.
	always_ff @(posedge clk) begin
		fixed_x <= sat(px_s3);
		fixed_y <= sat(py_s3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s1 <= chk_acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			done <= v_s3;
		end
	end

	`ASSERT_PROP(a_busy_once, clk, arst_n, !busy |=> !busy, "clearing sweep restarted")
	`ASSERT_PROP(a_no_check_in_clear, clk, arst_n, busy |=> !v_s1, "check entered during clear")
	`ASSERT_NEVER(a_no_write_in_clear, clk, arst_n, clr_q && wr_acc, "write taken during clear")
	`ASSERT_PROP(a_x_kept, clk, arst_n, v_s2 && !cw_s2 && !ce_s2 |=> px_s3 == $past(px_e), "x moved")
	`ASSERT_PROP(a_done_follows, clk, arst_n, done |-> $past(v_s3), "result without check")

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// Testbench for tile_wall_circle_collision: directed table, then random phases.
// Depends on twcc_pkg and the block's RTL; it predicts checks from its own wall map unless the table gives the result.

module tb;

	localparam int SIDE = 64;
	localparam int FRAC = 8;
	localparam int ONE = 1 << FRAC;
	localparam int NUM_PHASES = 5;
	localparam int PHASE_ITEMS = 186;
	localparam int DIR_ROWS = 20;
	localparam logic WR  = twcc_pkg::REQ_WRITE;
	localparam logic CHK = twcc_pkg::REQ_CHECK;

	typedef logic signed [twcc_pkg::POS_W-1:0] pos_t;
	typedef logic [twcc_pkg::TILE_W-1:0]       tile_t;
	typedef logic [twcc_pkg::WALL_W-1:0]       wall_t;
	typedef logic [twcc_pkg::CFG_DATA_W-1:0]   cfg_data_t;

	typedef struct packed {
		pos_t fx;
		pos_t fy;
	} pos_pair_t;

	typedef struct {
		logic  kind;
		tile_t col;
		tile_t row;
		wall_t walls;
		pos_t  px;
		pos_t  py;
		bit    known;
		pos_t  want_x;
		pos_t  want_y;
	} stim_row_t;

	logic                                clk;
	logic                                arst_n;
	logic                                start;
	logic                                busy;
	logic                                req_type;
	tile_t                               tile_col;
	tile_t                               tile_row;
	wall_t                               wall_bits;
	pos_t                                pos_x;
	pos_t                                pos_y;
	logic                                done;
	pos_t                                fixed_x;
	pos_t                                fixed_y;
	logic                                cfg_valid;
	logic                                cfg_ready;
	twcc_pkg::cfg_reg_t                  cfg_index;
	cfg_data_t                           cfg_data;

	// Shadow of the block's state.
	wall_t                         wall_mem [SIDE*SIDE];
	logic [twcc_pkg::SIZE_W-1:0]   map_w;
	logic [twcc_pkg::SIZE_W-1:0]   map_h;
	logic [twcc_pkg::RAD_W-1:0]    rad;

	pos_pair_t fix_q [$];
	int        err_count;
	stim_row_t plan [DIR_ROWS];

	tile_wall_circle_collision dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req_type  (req_type),
		.tile_col  (tile_col),
		.tile_row  (tile_row),
		.wall_bits (wall_bits),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.done      (done),
		.fixed_x   (fixed_x),
		.fixed_y   (fixed_y),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1000000;
		$display("tb: failure");
		$finish;
	end

	function automatic wall_t walls_at(longint c, longint r);
		if (c < 0 || r < 0)
			return '0;
		if (c >= longint'(map_w) || r >= longint'(map_h))
			return '0;
		if (c >= SIDE || r >= SIDE)
			return '0;
		return wall_mem[r*SIDE + c];
	endfunction

	function automatic pos_t clamp_pos(longint v);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (twcc_pkg::POS_W-1)) - 1;
		lo = -(longint'(1) <<< (twcc_pkg::POS_W-1));
		if (v > hi)
			v = hi;
		if (v < lo)
			v = lo;
		return pos_t'(v);
	endfunction

	// Pushes a circle back off the walls of its home tile and, on a corner hit,
	// off the outer walls of the diagonal neighbor.
	function automatic pos_pair_t correct_position(pos_t in_x, pos_t in_y);
		longint px, py, r, x, y, west, east, south, north;
		longint fx, fy, gap_w, gap_e, x_lo, x_hi, y_lo, y_hi;
		longint ny, y_fix, y_dist;
		wall_t here;
		wall_t diag;
		bit is_south, y_done;
		int y_side, y_outer;
		pos_pair_t res;
		px = longint'(in_x);
		py = longint'(in_y);
		r = longint'(rad);
		x = px >>> FRAC;
		y = py >>> FRAC;
		west = (px - r) >>> FRAC;
		east = (px + r) >>> FRAC;
		south = (py - r) >>> FRAC;
		north = (py + r) >>> FRAC;
		fx = px & (ONE - 1);
		fy = py & (ONE - 1);
		gap_w = fx;
		gap_e = (fx != 0) ? ONE - fx : 0;
		x_lo = x*ONE + r;
		x_hi = x*ONE + ONE - r;
		y_lo = y*ONE + r;
		y_hi = y*ONE + ONE - r;
		here = walls_at(x, y);
		if (south < y || north > y) begin
			is_south = south < y;
			ny = is_south ? south : north;
			y_fix = is_south ? y_lo : y_hi;
			y_dist = is_south ? fy : ((fy != 0) ? ONE - fy : 0);
			y_side = is_south ? twcc_pkg::BIT_SOUTH : twcc_pkg::BIT_NORTH;
			y_outer = is_south ? twcc_pkg::BIT_NORTH : twcc_pkg::BIT_SOUTH;
			y_done = here[y_side];
			if (y_done)
				py = y_fix;
			if (west < x) begin
				if (here[twcc_pkg::BIT_WEST]) begin
					px = x_lo;
				end else if (!y_done) begin
					diag = walls_at(west, ny);
					if (diag[y_outer] || diag[twcc_pkg::BIT_EAST]) begin
						if (y_dist > gap_w)
							py = y_fix;
						else
							px = x_lo;
					end
				end
			end else if (east > x) begin
				if (here[twcc_pkg::BIT_EAST]) begin
					px = x_hi;
				end else if (!y_done) begin
					diag = walls_at(east, ny);
					if (diag[y_outer] || diag[twcc_pkg::BIT_WEST]) begin
						if (y_dist > gap_e)
							py = y_fix;
						else
							px = x_hi;
					end
				end
			end
		end else if (west < x) begin
			if (here[twcc_pkg::BIT_WEST])
				px = x_lo;
		end else if (east > x) begin
			if (here[twcc_pkg::BIT_EAST])
				px = x_hi;
		end
		res.fx = clamp_pos(px);
		res.fy = clamp_pos(py);
		return res;
	endfunction

	// All driving tasks are entered and left at a falling edge.
	task automatic send_request(logic kind, tile_t col, tile_t row, wall_t walls,
			pos_t px, pos_t py, bit known, pos_pair_t want);
		start = 1'b1;
		req_type = kind;
		tile_col = col;
		tile_row = row;
		wall_bits = walls;
		pos_x = px;
		pos_y = py;
		do
			@(posedge clk);
		while (busy);
		if (kind == twcc_pkg::REQ_WRITE)
			wall_mem[row*SIDE + col] = walls;
		else if (known)
			fix_q.push_back(want);
		else
			fix_q.push_back(correct_position(px, py));
		@(negedge clk);
		start = 1'b0;
	endtask

	task automatic write_reg(twcc_pkg::cfg_reg_t idx, cfg_data_t val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			twcc_pkg::REG_MAP_WIDTH:  map_w = val[twcc_pkg::SIZE_W-1:0];
			twcc_pkg::REG_MAP_HEIGHT: map_h = val[twcc_pkg::SIZE_W-1:0];
			twcc_pkg::REG_RADIUS:     rad = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic wait_drained();
		while (fix_q.size() != 0)
			@(negedge clk);
	endtask

	// Random request: mostly checks near the tiles in use, some anywhere.
	task automatic random_request();
		logic kind;
		tile_t col, row;
		pos_t px, py;
		int tx, ty;
		pos_pair_t none;
		none = '0;
		kind = ($urandom_range(2) == 0) ? twcc_pkg::REQ_WRITE : twcc_pkg::REQ_CHECK;
		if ($urandom_range(4) == 0) begin
			col = tile_t'($urandom_range(SIDE-1));
			row = tile_t'($urandom_range(SIDE-1));
		end else begin
			col = tile_t'($urandom_range(int'(map_w) - 1));
			row = tile_t'($urandom_range(int'(map_h) - 1));
		end
		if ($urandom_range(9) == 0) begin
			px = pos_t'($urandom());
			py = pos_t'($urandom());
		end else begin
			tx = int'($urandom_range(int'(map_w) + 1)) - 1;
			ty = int'($urandom_range(int'(map_h) + 1)) - 1;
			px = pos_t'(tx*ONE + int'($urandom_range(ONE-1)));
			py = pos_t'(ty*ONE + int'($urandom_range(ONE-1)));
		end
		send_request(kind, col, row, wall_t'($urandom()), px, py, 1'b0, none);
	endtask

	// Results cannot be held off, so every strobe is checked at once.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (fix_q.size() == 0) begin
				err_count++;
				$display("%0t: result with nothing expected, actual x=%0d y=%0d",
					$time, fixed_x, fixed_y);
			end else if (fixed_x !== fix_q[0].fx || fixed_y !== fix_q[0].fy) begin
				err_count++;
				$display("%0t: mismatch, expected x=%0d y=%0d, actual x=%0d y=%0d",
					$time, fix_q[0].fx, fix_q[0].fy, fixed_x, fixed_y);
				void'(fix_q.pop_front());
			end else begin
				void'(fix_q.pop_front());
			end
		end
	end

	initial begin
		int ph_w [NUM_PHASES];
		int ph_h [NUM_PHASES];
		int ph_r [NUM_PHASES];
		int ph_idle [NUM_PHASES];
		pos_pair_t want;
		arst_n = 1'b0;
		start = 1'b0;
		req_type = twcc_pkg::REQ_WRITE;
		tile_col = '0;
		tile_row = '0;
		wall_bits = '0;
		pos_x = '0;
		pos_y = '0;
		cfg_valid = 1'b0;
		cfg_index = twcc_pkg::REG_MAP_WIDTH;
		cfg_data = '0;
		err_count = 0;
		foreach (wall_mem[i])
			wall_mem[i] = '0;
		map_w = twcc_pkg::MAP_SIZE_RESET;
		map_h = twcc_pkg::MAP_SIZE_RESET;
		rad = twcc_pkg::RADIUS_RESET;

		ph_w = '{64, 1, 64, 1 + int'($urandom_range(63)), 13};
		ph_h = '{64, 1, 64, 1 + int'($urandom_range(63)), 40};
		ph_r = '{64, 255, 0, int'($urandom_range(255)), 128};
		ph_idle = '{0, 55, 0, 22, 55};

		// Runs at the reset settings: radius a quarter tile, full 64 x 64 map.
		plan = '{
			'{CHK, 6'd0, 6'd0, 8'h00, 24'h000180, 24'h000180, 1'b1, 24'h000180, 24'h000180},
			'{CHK, 6'd0, 6'd0, 8'h00, 24'h7FFFFF, 24'h7FFFFF, 1'b1, 24'h7FFFFF, 24'h7FFFFF},
			'{CHK, 6'd0, 6'd0, 8'h00, 24'h800000, 24'h800000, 1'b1, 24'h800000, 24'h800000},
			'{WR, 6'd0, 6'd0, 8'h0F, 24'h000000, 24'h000000, 1'b0, 24'h0, 24'h0},
			'{CHK, 6'd63, 6'd63, 8'hFF, 24'h000020, 24'h000020, 1'b1, 24'h000040, 24'h000040},
			'{CHK, 6'd0, 6'd0, 8'h00, 24'h0000F0, 24'h0000F0, 1'b1, 24'h0000C0, 24'h0000C0},
			'{CHK, 6'd0, 6'd0, 8'h00, 24'h000080, 24'h000080, 1'b1, 24'h000080, 24'h000080},
			'{WR, 6'd1, 6'd1, 8'hF0, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 24'h0, 24'h0},
			'{CHK, 6'd0, 6'd0, 8'h00, 24'h000120, 24'h000180, 1'b1, 24'h000120, 24'h000180},
			'{CHK, 6'd0, 6'd0, 8'h00, 24'h000110, 24'h000120, 1'b0, 24'h0, 24'h0},
			'{CHK, 6'd0, 6'd0, 8'h00, 24'h000120, 24'h000120, 1'b0, 24'h0, 24'h0},
			'{CHK, 6'd0, 6'd0, 8'h00, 24'h000130, 24'h000110, 1'b0, 24'h0, 24'h0},
			'{WR, 6'd2, 6'd2, 8'h04, 24'h000000, 24'h000000, 1'b0, 24'h0, 24'h0},
			'{CHK, 6'd0, 6'd0, 8'h00, 24'h0001E0, 24'h0001F0, 1'b0, 24'h0, 24'h0},
			'{WR, 6'd63, 6'd63, 8'hFF, 24'h000000, 24'h000000, 1'b0, 24'h0, 24'h0},
			'{CHK, 6'd0, 6'd0, 8'h00, 24'h003FF8, 24'h003FF8, 1'b1, 24'h003FC0, 24'h003FC0},
			'{CHK, 6'd0, 6'd0, 8'h00, 24'hFFFFF0, 24'h000080, 1'b1, 24'hFFFFF0, 24'h000080},
			'{CHK, 6'd0, 6'd0, 8'h00, 24'hFFFFF0, 24'hFFFFF0, 1'b0, 24'h0, 24'h0},
			'{WR, 6'd0, 6'd0, 8'h00, 24'h000000, 24'h000000, 1'b0, 24'h0, 24'h0},
			'{CHK, 6'd0, 6'd0, 8'h00, 24'h000020, 24'h000020, 1'b1, 24'h000020, 24'h000020}
		};

		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		foreach (plan[i]) begin
			want.fx = plan[i].want_x;
			want.fy = plan[i].want_y;
			send_request(plan[i].kind, plan[i].col, plan[i].row, plan[i].walls,
				plan[i].px, plan[i].py, plan[i].known, want);
		end

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			// A trailing write produces no strobe, so give the pipeline time to settle.
			wait_drained();
			repeat (8) @(negedge clk);
			write_reg(twcc_pkg::REG_MAP_WIDTH, cfg_data_t'(ph_w[ph]));
			write_reg(twcc_pkg::REG_MAP_HEIGHT, cfg_data_t'(ph_h[ph]));
			write_reg(twcc_pkg::REG_RADIUS, cfg_data_t'(ph_r[ph]));
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (int'($urandom_range(99)) < ph_idle[ph])
					repeat ($urandom_range(1, 4)) @(negedge clk);
				if (ph == 1 && $urandom_range(24) == 0)
					wait_drained();
				random_request();
			end
		end

		wait_drained();
		repeat (10) @(negedge clk);
		if (err_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== tile_wall_circle_collision.f =====
+incdir+hdl
hdl/twcc_pkg.sv
hdl/twcc_ram.sv
hdl/tile_wall_circle_collision.sv
sim/tb.sv
